// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define GBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that is checked during reset too
`define GBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/gbs_pkg.sv =====
// package: types, constants and codes of the greedy box suppression block
package gbs_pkg;

    localparam int MAX_KEPT        = 256;
    localparam int MAX_FRAME_BOXES = 4096;
    localparam int KEPT_IDX_W      = $clog2(MAX_KEPT);
    localparam int KEPT_CNT_W      = $clog2(MAX_KEPT + 1);
    localparam int COORD_W         = 16;
    localparam int THR_W           = 17;
    localparam int AREA_W          = 34;
    localparam int INTER_W         = 34;
    localparam int BOX_NUM_W       = 12;
    localparam int CNT_LIMIT_I     = (MAX_FRAME_BOXES - 1 > 4095) ? 4095 : MAX_FRAME_BOXES - 1;
    localparam logic [BOX_NUM_W-1:0] CNT_LIMIT = BOX_NUM_W'(CNT_LIMIT_I);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_ONE_BIAS  = 2'd1;

    typedef struct packed {
        logic [COORD_W-1:0] left_edge;
        logic [COORD_W-1:0] top_edge;
        logic [COORD_W-1:0] right_edge;
        logic [COORD_W-1:0] bottom_edge;
        logic               frame_end;
    } gbs_in_t;

    typedef struct packed {
        logic [BOX_NUM_W-1:0] box_number;
        logic                 keep;
        logic                 store_overflow;
        logic                 final_box;
    } gbs_out_t;

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
    } box_t;

    typedef struct packed {
        box_t                     box;
        logic signed [AREA_W-1:0] area;
    } kept_entry_t;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } iou_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } gbs_state_t;

endpackage

// ===== sv/gbs_cell.sv =====
// one cell of the kept-box chain: holds an entry, rotates toward the head
module gbs_cell
    import gbs_pkg::*;
(
    input  logic        clk,
    input  logic        shift_en,
    input  logic        tail,
    input  logic        load,
    input  kept_entry_t nbr_data,
    input  kept_entry_t wrap_data,
    input  kept_entry_t load_data,
    output kept_entry_t data
);

    kept_entry_t entry_reg;
    kept_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (load)
        begin
            entry_next = load_data;
        end
        else if (shift_en)
        begin
            // the tail cell takes the head entry back
            entry_next = tail ? wrap_data : nbr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

// ===== sv/gbs_iou.sv =====
// pipelined overlap test of one kept box against the new box
module gbs_iou
    import gbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     valid_in,
    input  kept_entry_t              kept,
    input  box_t                     nbox,
    input  logic signed [AREA_W-1:0] narea,
    input  logic                     bias,
    input  logic [THR_W-1:0]         thr,
    output iou_status_t              status
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic [COORD_W-1:0] xl, xh, yl, yh;
    logic signed [COORD_W+1:0] w_raw, h_raw, bias_ext;
    logic [COORD_W:0] w_reg, h_reg;
    logic signed [AREA_W:0] asum1_reg, asum2_reg;
    logic [INTER_W-1:0] inter2_reg, inter3_reg, inter4_reg;
    logic signed [AREA_W:0] uni_next;
    logic [AREA_W-1:0] uni3_reg;
    logic pos3_reg, pos4_reg;
    logic [THR_W+17:0] plo_reg;
    logic [THR_W+15:0] phi_reg;
    logic [THR_W+AREA_W-1:0] prod;
    logic [THR_W+AREA_W-1:0] lhs;
    logic hit_reg;

    always_comb
    begin
        xl = (kept.box.x1 > nbox.x1) ? kept.box.x1 : nbox.x1;
        xh = (kept.box.x2 < nbox.x2) ? kept.box.x2 : nbox.x2;
        yl = (kept.box.y1 > nbox.y1) ? kept.box.y1 : nbox.y1;
        yh = (kept.box.y2 < nbox.y2) ? kept.box.y2 : nbox.y2;
        bias_ext = $signed({13'd0, bias, 4'd0});
        w_raw = $signed({2'b00, xh}) - $signed({2'b00, xl}) + bias_ext;
        h_raw = $signed({2'b00, yh}) - $signed({2'b00, yl}) + bias_ext;
        uni_next = asum2_reg - $signed({1'b0, inter2_reg});
        prod = {phi_reg, 18'd0} + {16'd0, plo_reg};
        lhs = {1'b0, inter4_reg, 16'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: clamped overlap extents, area sum
        w_reg     <= w_raw[COORD_W+1] ? '0 : w_raw[COORD_W:0];
        h_reg     <= h_raw[COORD_W+1] ? '0 : h_raw[COORD_W:0];
        asum1_reg <= {kept.area[AREA_W-1], kept.area} + {narea[AREA_W-1], narea};
        // stage 2: intersection
        inter2_reg <= w_reg * h_reg;
        asum2_reg  <= asum1_reg;
        // stage 3: union, positive only when it can suppress
        uni3_reg   <= uni_next[AREA_W-1:0];
        pos3_reg   <= !uni_next[AREA_W] && (uni_next != '0);
        inter3_reg <= inter2_reg;
        // stage 4: threshold times union in two partial products
        plo_reg    <= thr * uni3_reg[17:0];
        phi_reg    <= thr * uni3_reg[AREA_W-1:18];
        pos4_reg   <= pos3_reg;
        inter4_reg <= inter3_reg;
        // stage 5: compare
        hit_reg    <= pos4_reg && (lhs >= prod);
    end

    assign status.busy      = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign status.hit_valid = v5_reg;
    assign status.hit       = hit_reg;

endmodule

// ===== sv/greedy_box_suppression_top.sv =====
// greedy box suppression: each accepted box is checked against the kept boxes and gets one result word
// one box at a time: the next box is taken only after the result of the last has been registered
// a box passes the accept, area, scan, drain and result steps; scan and drain are skipped when the store is empty
// result register lets the next box enter while a result word waits; done stalls until it drains
// asynchronous active-low reset clears counters, threshold 0.5, bias off
// store contents are not cleared; only the first kept_count cells are read
module greedy_box_suppression_top
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gbs_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gbs_out_t              out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    gbs_state_t state_reg, state_next;

    // configuration registers
    logic [THR_W-1:0] thr_reg;
    logic             bias_reg;

    // counters
    logic [KEPT_CNT_W-1:0] count_reg, count_next;
    logic [KEPT_CNT_W-1:0] scan_reg, scan_next;
    logic [BOX_NUM_W-1:0]  boxnum_reg, boxnum_next;
    logic                  supp_reg, supp_next;

    // new box word
    box_t                     nbox_reg;
    logic                     fend_reg;
    logic signed [AREA_W-1:0] narea_reg;

    // result register
    logic     out_valid_reg, out_valid_next;
    gbs_out_t out_data_reg;

    // fsm decodes
    logic accept_in;
    logic area_en;
    logic scan_en;
    logic finish;
    logic store_en;

    logic signed [COORD_W+1:0] dx, dy, bias_ext;
    logic signed [2*COORD_W+3:0] area_full;
    logic [KEPT_IDX_W-1:0] tail_idx;
    logic keep_w;

    kept_entry_t cells   [MAX_KEPT];
    kept_entry_t new_ent;
    iou_status_t iou_st;

    assign cfg_ready = 1'b1;

    // config decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            bias_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IOU_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                CFG_ADD_ONE_BIAS:  bias_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_AREA;
                end
            end
            ST_AREA:
            begin
                state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_reg + 1'b1 == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!iou_st.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        area_en  = 1'b0;
        scan_en  = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_AREA:  area_en  = 1'b1;
            ST_SCAN:  scan_en  = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  finish   = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    assign accept_in = in_valid && in_ready;
    assign keep_w    = !supp_reg;
    assign store_en  = finish && keep_w && (count_reg < KEPT_CNT_W'(MAX_KEPT));
    assign tail_idx  = KEPT_IDX_W'(count_reg - 1'b1);

    // area of the new box, signed, bias optional
    always_comb
    begin
        bias_ext  = $signed({13'd0, bias_reg, 4'd0});
        dx        = $signed({2'b00, nbox_reg.x2}) - $signed({2'b00, nbox_reg.x1}) + bias_ext;
        dy        = $signed({2'b00, nbox_reg.y2}) - $signed({2'b00, nbox_reg.y1}) + bias_ext;
        area_full = dx * dy;
    end

    // counters and result
    always_comb
    begin
        count_next     = count_reg;
        scan_next      = scan_reg;
        boxnum_next    = boxnum_reg;
        supp_next      = supp_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept_in)
        begin
            supp_next = 1'b0;
            scan_next = '0;
        end
        if (scan_en)
        begin
            scan_next = scan_reg + 1'b1;
        end
        if (iou_st.hit_valid && iou_st.hit)
        begin
            supp_next = 1'b1;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
            if (store_en)
            begin
                count_next = count_reg + 1'b1;
            end
            if (boxnum_reg < CNT_LIMIT)
            begin
                boxnum_next = boxnum_reg + 1'b1;
            end
            // last box of the frame empties the store
            if (fend_reg)
            begin
                count_next  = '0;
                boxnum_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            boxnum_reg    <= '0;
            supp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            boxnum_reg    <= boxnum_next;
            supp_reg      <= supp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            nbox_reg.x1 <= in_data.left_edge;
            nbox_reg.y1 <= in_data.top_edge;
            nbox_reg.x2 <= in_data.right_edge;
            nbox_reg.y2 <= in_data.bottom_edge;
            fend_reg    <= in_data.frame_end;
        end
        if (area_en)
        begin
            narea_reg <= area_full[AREA_W-1:0];
        end
        if (finish)
        begin
            out_data_reg.box_number     <= boxnum_reg;
            out_data_reg.keep           <= keep_w;
            out_data_reg.store_overflow <= keep_w && !store_en;
            out_data_reg.final_box      <= fend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // kept-box chain: the active cells rotate one step per scan cycle
    assign new_ent.box  = nbox_reg;
    assign new_ent.area = narea_reg;

    for (genvar j = 0; j < MAX_KEPT; j++)
    begin : g_cell
        kept_entry_t nbr;
        if (j == MAX_KEPT - 1)
        begin : g_last
            assign nbr = cells[0];
        end
        else
        begin : g_mid
            assign nbr = cells[j+1];
        end

        gbs_cell u_cell (
            .clk       (clk),
            .shift_en  (scan_en && (KEPT_CNT_W'(j) < count_reg)),
            .tail      (tail_idx == KEPT_IDX_W'(j)),
            .load      (store_en && (count_reg[KEPT_IDX_W-1:0] == KEPT_IDX_W'(j))),
            .nbr_data  (nbr),
            .wrap_data (cells[0]),
            .load_data (new_ent),
            .data      (cells[j])
        );
    end

    // overlap test against the head cell
    gbs_iou u_iou (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (scan_en),
        .kept     (cells[0]),
        .nbox     (nbox_reg),
        .narea    (narea_reg),
        .bias     (bias_reg),
        .thr      (thr_reg),
        .status   (iou_st)
    );

endmodule

// ===== sv/gbs_checker.sv =====
// port-level checker for the greedy box suppression top, with its bind
`include "assert_macros.svh"

module gbs_checker
    import gbs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input gbs_out_t              out_data
);

    // a waiting result word stays up
    `GBS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")

    // overflow only on a kept box
    `GBS_ASSERT(a_ovf_keep, out_valid && out_data.store_overflow |-> out_data.keep, "bad overflow")

    // one box at a time
    `GBS_ASSERT(a_one_box, in_valid && in_ready |=> !in_ready, "second box taken while busy")

    // a new result only follows a busy cycle
    `GBS_ASSERT(a_out_busy, $rose(out_valid) |-> $past(!in_ready), "result while idle")

    // nothing valid leaves during reset
    `GBS_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !out_valid, "result during reset")

endmodule

bind greedy_box_suppression_top gbs_checker u_gbs_checker (.*);
